@@ rtl/grmc_pkg.sv @@
// grmc_pkg: shared types and constants of the grid rotation block
`timescale 1ns / 1ps

package grmc_pkg;

   // item opcodes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   // result status codes
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_NOT_READY = 1'b1;

   // register index of side_length
   localparam int unsigned REG_SIDE_LENGTH = 0;

   // rotation picked by the corner that holds the local minimum
   typedef enum logic [1:0] {
      ROT_TL = 2'd0,
      ROT_TR = 2'd1,
      ROT_BL = 2'd2,
      ROT_BR = 2'd3
   } rot_mode_type;

   // corner slot positions: 0 -> first, 1 -> second, 2 -> last, 3 -> last but one
   localparam int unsigned CORNER_SLOTS = 9;
   typedef logic [1:0] pos_sel_type;
   localparam pos_sel_type CORNER_ROW_SEL [CORNER_SLOTS] =
      '{2'd0, 2'd0, 2'd1, 2'd0, 2'd0, 2'd1, 2'd2, 2'd3, 2'd2};
   localparam pos_sel_type CORNER_COL_SEL [CORNER_SLOTS] =
      '{2'd0, 2'd1, 2'd0, 2'd2, 2'd3, 2'd2, 2'd0, 2'd0, 2'd1};

   // result flags waiting in the read stage
   typedef struct packed {
      logic end_of_row;
      logic end_of_grid;
      logic status;
   } rsp_flags_type;

endpackage

@@ rtl/grid_rotate_to_min_corner.sv @@
// grid_rotate_to_min_corner: grid store with rotated read-out by 90 degree steps
//
// Usage: a square grid of side_length x side_length words is loaded in
// row-major order with load words (req_operation = load) on the req_ channel.
// The last load picks the rotation from the corner whose value lies strictly
// below both neighbours (top-left, top-right, bottom-left, else bottom-right).
// Each fetch word then returns the next cell of the rotated grid on the rsp_
// channel with end-of-row and end-of-grid marks; a fetch with no complete grid
// returns status 1. Loads give no response word and are dropped while a grid
// is held until it has been read out.
// Throughput: one word per cycle for loads and fetches while rsp_ready does not
// hold the flow; the grid memory has a single write port and a single registered
// read port. Path: an accepted fetch reads the memory into the read stage, then
// the result moves on to the output register, where rsp_valid rises.
// Stall: while rsp_ready is low the result waits in the output register, one
// more read waits behind it, and req_ready drops when both are full.
// Reset clears all control state; the grid memory is not cleared and needs no
// clearing pass, since each read hits a cell of the grid loaded just before.
// Writing side_length (APB, address 0; only paddr[2] is decoded) restarts loading and read-out.
`timescale 1ns / 1ps

module grid_rotate_to_min_corner #(
   parameter int unsigned MAX_SIDE   = 128,
   parameter int unsigned VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [31:0] req_cell_value,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_out_value,
   output logic        rsp_end_of_row,
   output logic        rsp_end_of_grid,
   output logic        rsp_status,
   // configuration
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import grmc_pkg::*;

   localparam int unsigned RB        = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
   localparam int unsigned AB        = 2 * RB;
   localparam int unsigned MEM_DEPTH = 1 << AB;
   localparam int unsigned SW        = (VALUE_BITS < 32) ? VALUE_BITS : 32;
   localparam logic [RB-1:0] LAST_MAX = RB'(MAX_SIDE - 1);
   localparam logic [RB-1:0] LAST_MIN = RB'(1);

   // configuration
   logic [7:0]    side_ff, side_in;
   logic [RB-1:0] last_ff, last_in;
   logic          cfg_wr;

   // load side
   logic [RB-1:0] load_row_ff, load_row_in;
   logic [RB-1:0] load_col_ff, load_col_in;
   logic          loaded_ff, loaded_in;
   logic [SW-1:0] corner_ff [CORNER_SLOTS];
   logic [SW-1:0] corner_in [CORNER_SLOTS];
   rot_mode_type  mode_ff, mode_in;
   logic [RB-1:0] pos [4];
   logic [SW-1:0] load_value;

   // fetch side
   logic [RB-1:0] emit_row_ff, emit_row_in;
   logic [RB-1:0] emit_col_ff, emit_col_in;
   logic [RB-1:0] src_row, src_col;
   logic          eor, eog;

   // read stage and output register
   logic          pend_ff, pend_in;
   rsp_flags_type pend_flags_ff, pend_flags_in;
   logic [SW-1:0] rd_data_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_flags_type rsp_flags_ff, rsp_flags_in;
   logic [SW-1:0] rsp_data_ff, rsp_data_in;
   logic          pend_move;

   logic          req_acc, load_acc, fetch_acc, do_load, last_load, do_read;
   logic [AB-1:0] wr_addr, rd_addr;

   logic [SW-1:0] mem [MEM_DEPTH];

   // handshakes
   assign pend_move = !rsp_valid_ff || rsp_ready;
   assign req_ready = !pend_ff || pend_move;
   assign req_acc   = req_valid && req_ready;
   assign load_acc  = req_acc && (req_operation == OP_LOAD);
   assign fetch_acc = req_acc && (req_operation == OP_FETCH);
   assign do_load   = load_acc && !loaded_ff;
   assign last_load = do_load && (load_row_ff == last_ff) && (load_col_ff == last_ff);
   assign do_read   = fetch_acc && loaded_ff;

   // configuration port
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && (32'(paddr[2]) == REG_SIDE_LENGTH);
   assign prdata = (32'(paddr[2]) == REG_SIDE_LENGTH) ? {24'd0, side_ff} : 32'd0;

   always_comb begin
      side_in = side_ff;
      last_in = last_ff;
      if (cfg_wr) begin
         side_in = pwdata[7:0];
         if (pwdata[7:0] < 8'd2) begin
            last_in = LAST_MIN;
         end else if (32'(pwdata[7:0]) > 32'(MAX_SIDE)) begin
            last_in = LAST_MAX;
         end else begin
            last_in = RB'(32'(pwdata[7:0]) - 32'd1);
         end
      end
   end

   // corner capture during loading
   assign load_value = req_cell_value[SW-1:0];
   assign pos[0] = '0;
   assign pos[1] = RB'(1);
   assign pos[2] = last_ff;
   assign pos[3] = last_ff - RB'(1);

   always_comb begin
      for (int k = 0; k < CORNER_SLOTS; k++) begin
         corner_in[k] = corner_ff[k];
         if (do_load && (load_row_ff == pos[CORNER_ROW_SEL[k]])
                     && (load_col_ff == pos[CORNER_COL_SEL[k]])) begin
            corner_in[k] = load_value;
         end
      end
   end

   // the last cell can itself be a corner neighbour, so pick from the updated slots
   always_comb begin
      mode_in = mode_ff;
      if (last_load) begin
         if (corner_in[0] < corner_in[1] && corner_in[0] < corner_in[2]) begin
            mode_in = ROT_TL;
         end else if (corner_in[3] < corner_in[4] && corner_in[3] < corner_in[5]) begin
            mode_in = ROT_TR;
         end else if (corner_in[6] < corner_in[7] && corner_in[6] < corner_in[8]) begin
            mode_in = ROT_BL;
         end else begin
            mode_in = ROT_BR;
         end
      end
   end

   // source cell of the next rotated output cell
   always_comb begin
      case (mode_ff)
         ROT_TL: begin
            src_row = emit_row_ff;
            src_col = emit_col_ff;
         end
         ROT_TR: begin
            src_row = emit_col_ff;
            src_col = last_ff - emit_row_ff;
         end
         ROT_BL: begin
            src_row = last_ff - emit_col_ff;
            src_col = emit_row_ff;
         end
         default: begin
            src_row = last_ff - emit_row_ff;
            src_col = last_ff - emit_col_ff;
         end
      endcase
   end

   assign eor     = (emit_col_ff == last_ff);
   assign eog     = eor && (emit_row_ff == last_ff);
   assign wr_addr = {load_row_ff, load_col_ff};
   assign rd_addr = {src_row, src_col};

   // counters and load state
   always_comb begin
      load_row_in = load_row_ff;
      load_col_in = load_col_ff;
      loaded_in   = loaded_ff;
      emit_row_in = emit_row_ff;
      emit_col_in = emit_col_ff;
      if (cfg_wr) begin
         load_row_in = '0;
         load_col_in = '0;
         loaded_in   = 1'b0;
         emit_row_in = '0;
         emit_col_in = '0;
      end else if (last_load) begin
         load_row_in = '0;
         load_col_in = '0;
         loaded_in   = 1'b1;
         emit_row_in = '0;
         emit_col_in = '0;
      end else if (do_load) begin
         if (load_col_ff == last_ff) begin
            load_col_in = '0;
            load_row_in = load_row_ff + RB'(1);
         end else begin
            load_col_in = load_col_ff + RB'(1);
         end
      end else if (do_read) begin
         if (eog) begin
            loaded_in   = 1'b0;
            emit_row_in = '0;
            emit_col_in = '0;
         end else if (eor) begin
            emit_row_in = emit_row_ff + RB'(1);
            emit_col_in = '0;
         end else begin
            emit_col_in = emit_col_ff + RB'(1);
         end
      end
   end

   // read stage and output register
   always_comb begin
      pend_in       = pend_ff && !pend_move;
      pend_flags_in = pend_flags_ff;
      if (fetch_acc) begin
         pend_in                   = 1'b1;
         pend_flags_in.end_of_row  = loaded_ff && eor;
         pend_flags_in.end_of_grid = loaded_ff && eog;
         pend_flags_in.status      = loaded_ff ? STATUS_OK : STATUS_NOT_READY;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_flags_in = rsp_flags_ff;
      rsp_data_in  = rsp_data_ff;
      if (pend_ff && pend_move) begin
         rsp_valid_in = 1'b1;
         rsp_flags_in = pend_flags_ff;
         rsp_data_in  = (pend_flags_ff.status == STATUS_OK) ? rd_data_ff : '0;
      end
   end

   // grid memory
   always_ff @(posedge clock) begin
      if (do_load) begin
         mem[wr_addr] <= load_value;
      end
   end

   always_ff @(posedge clock) begin
      if (do_read) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      corner_ff     <= corner_in;
      pend_flags_ff <= pend_flags_in;
      rsp_flags_ff  <= rsp_flags_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff      <= 8'd2;
         last_ff      <= LAST_MIN;
         load_row_ff  <= '0;
         load_col_ff  <= '0;
         loaded_ff    <= 1'b0;
         mode_ff      <= ROT_TL;
         emit_row_ff  <= '0;
         emit_col_ff  <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         side_ff      <= side_in;
         last_ff      <= last_in;
         load_row_ff  <= load_row_in;
         load_col_ff  <= load_col_in;
         loaded_ff    <= loaded_in;
         mode_ff      <= mode_in;
         emit_row_ff  <= emit_row_in;
         emit_col_ff  <= emit_col_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_value   = 32'(rsp_data_ff);
   assign rsp_end_of_row  = rsp_flags_ff.end_of_row;
   assign rsp_end_of_grid = rsp_flags_ff.end_of_grid;
   assign rsp_status      = rsp_flags_ff.status;

   // checks
   a_not_ready_word_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_out_value == 32'd0 && !rsp_end_of_row
                                  && !rsp_end_of_grid)
      else $error("status word carries data");

   a_eog_implies_eor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_grid |-> rsp_end_of_row)
      else $error("end of grid without end of row");

   a_fetch_reaches_read_stage: assert property (@(posedge clock) disable iff (reset)
      fetch_acc |=> pend_ff)
      else $error("accepted fetch lost before read stage");

   a_loaded_counters_idle: assert property (@(posedge clock) disable iff (reset)
      loaded_ff |-> load_row_ff == '0 && load_col_ff == '0)
      else $error("load counters moved while grid held");

   a_emit_idle_when_empty: assert property (@(posedge clock) disable iff (reset)
      !loaded_ff |-> emit_row_ff == '0 && emit_col_ff == '0)
      else $error("read-out counters moved without a grid");

endmodule
